### design/fbr_pkg.sv
// fbr_pkg: shared constants and types for the forced Brusselator RK4 block.
// No dependencies; used by fbr_alu and the top level by scoped names.
`timescale 1ns / 1ps
package fbr_pkg;
    localparam int VW = 40;
    localparam int FB = 24;
    localparam int FW = 26;
    localparam int SW = 25;

    typedef logic signed [VW-1:0] val_t;

    localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam val_t ONE_C = val_t'(64'sd1 <<< FB);
    localparam val_t HALF_C = val_t'(64'sd1 <<< (FB-1));
    localparam val_t SIXTH_C = val_t'(((64'sd1 <<< FB) + 64'sd3) / 64'sd6);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_S1 = 3'd5;
    localparam logic [2:0] REG_S2 = 3'd6;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
    } alu_cmd_t;
endpackage

### design/forced_brusselator_rk4_step.sv
// forced_brusselator_rk4_step: top level, sequencer, registers and state.
// Depends on fbr_pkg and fbr_alu.
`timescale 1ns / 1ps
// One word in carries a forcing sample and a restart flag; one word out carries
// the two concentrations after a full fourth-order Runge-Kutta step of the
// forced Brusselator. Every operation of the step (saturating add, subtract and
// multiply) runs in order through one shared arithmetic unit under a microcode
// sequencer: 71 operations per step, 36 additions and 35 products, each product
// passing through issue, four partial products, saturate and write back. s_ready is
// low while a step runs and while the result word waits on m_ready.
// Configuration writes are taken at any time but must only be issued idle.
module forced_brusselator_rk4_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [25:0]          s_forcing,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [39:0]          m_first_conc,
    output logic signed [39:0]          m_second_conc,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [39:0]                 cfg_data
);
    // register file slots for operands and temporaries
    localparam logic [4:0] R_ZERO = 5'd0,  R_ONE = 5'd1,  R_HALF = 5'd2,  R_SIX = 5'd3;
    localparam logic [4:0] R_A = 5'd4, R_B = 5'd5, R_C = 5'd6, R_D = 5'd7, R_H = 5'd8;
    localparam logic [4:0] R_OSC = 5'd9, R_X1 = 5'd10, R_X2 = 5'd11, R_PX = 5'd12;
    localparam logic [4:0] R_PY = 5'd13, R_FEED = 5'd14, R_BD = 5'd15, R_T = 5'd16;
    localparam logic [4:0] R_U = 5'd17, R_L = 5'd18, R_K = 5'd19, R_S1 = 5'd20;
    localparam logic [4:0] R_S2 = 5'd21, R_V = 5'd22;

    localparam logic [1:0] ST_IDLE = 2'd0, ST_ISSUE = 2'd1, ST_WAIT = 2'd2, ST_OUT = 2'd3;

    localparam int NOPS = 71;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [4:0] rd;
    } uop_t;

    function automatic uop_t mk(logic [1:0] op, logic [4:0] ra, logic [4:0] rb,
                                logic [4:0] rd);
        uop_t u;
        u.op = op; u.ra = ra; u.rb = rb; u.rd = rd;
        return u;
    endfunction

    // one derivative evaluation at (PX, PY) scaled by h into L and K
    function automatic uop_t deriv_op(logic [3:0] i);
        uop_t u;
        case (i)
            4'd0:    u = mk(fbr_pkg::OP_MUL, R_C,  R_PX, R_T);
            4'd1:    u = mk(fbr_pkg::OP_MUL, R_T,  R_PX, R_T);
            4'd2:    u = mk(fbr_pkg::OP_MUL, R_T,  R_PY, R_T);
            4'd3:    u = mk(fbr_pkg::OP_MUL, R_BD, R_PX, R_U);
            4'd4:    u = mk(fbr_pkg::OP_SUB, R_FEED, R_U, R_U);
            4'd5:    u = mk(fbr_pkg::OP_ADD, R_U,  R_T,  R_U);
            4'd6:    u = mk(fbr_pkg::OP_MUL, R_U,  R_H,  R_L);
            4'd7:    u = mk(fbr_pkg::OP_MUL, R_B,  R_PX, R_U);
            4'd8:    u = mk(fbr_pkg::OP_SUB, R_U,  R_T,  R_U);
            default: u = mk(fbr_pkg::OP_MUL, R_U,  R_H,  R_K);
        endcase
        return u;
    endfunction

    // full step microcode
    function automatic uop_t ucode(logic [6:0] pc);
        uop_t u;
        u = mk(fbr_pkg::OP_ADD, R_ZERO, R_ZERO, R_ZERO);
        if (pc < 7'd5) begin
            case (pc[2:0])
                3'd0:    u = mk(fbr_pkg::OP_ADD, R_ONE, R_OSC, R_FEED);
                3'd1:    u = mk(fbr_pkg::OP_MUL, R_A, R_FEED, R_FEED);
                3'd2:    u = mk(fbr_pkg::OP_ADD, R_B, R_D, R_BD);
                3'd3:    u = mk(fbr_pkg::OP_ADD, R_X1, R_ZERO, R_PX);
                default: u = mk(fbr_pkg::OP_ADD, R_X2, R_ZERO, R_PY);
            endcase
        end else if (pc < 7'd15) begin
            u = deriv_op(4'(pc - 7'd5));
        end else if (pc < 7'd21) begin
            case (pc)
                7'd15:   u = mk(fbr_pkg::OP_ADD, R_L, R_ZERO, R_S1);
                7'd16:   u = mk(fbr_pkg::OP_ADD, R_K, R_ZERO, R_S2);
                7'd17:   u = mk(fbr_pkg::OP_MUL, R_HALF, R_L, R_V);
                7'd18:   u = mk(fbr_pkg::OP_ADD, R_X1, R_V, R_PX);
                7'd19:   u = mk(fbr_pkg::OP_MUL, R_HALF, R_K, R_V);
                default: u = mk(fbr_pkg::OP_ADD, R_X2, R_V, R_PY);
            endcase
        end else if (pc < 7'd31) begin
            u = deriv_op(4'(pc - 7'd21));
        end else if (pc < 7'd39) begin
            case (pc)
                7'd31:   u = mk(fbr_pkg::OP_ADD, R_L, R_L, R_V);
                7'd32:   u = mk(fbr_pkg::OP_ADD, R_S1, R_V, R_S1);
                7'd33:   u = mk(fbr_pkg::OP_ADD, R_K, R_K, R_V);
                7'd34:   u = mk(fbr_pkg::OP_ADD, R_S2, R_V, R_S2);
                7'd35:   u = mk(fbr_pkg::OP_MUL, R_HALF, R_L, R_V);
                7'd36:   u = mk(fbr_pkg::OP_ADD, R_X1, R_V, R_PX);
                7'd37:   u = mk(fbr_pkg::OP_MUL, R_HALF, R_K, R_V);
                default: u = mk(fbr_pkg::OP_ADD, R_X2, R_V, R_PY);
            endcase
        end else if (pc < 7'd49) begin
            u = deriv_op(4'(pc - 7'd39));
        end else if (pc < 7'd55) begin
            case (pc)
                7'd49:   u = mk(fbr_pkg::OP_ADD, R_L, R_L, R_V);
                7'd50:   u = mk(fbr_pkg::OP_ADD, R_S1, R_V, R_S1);
                7'd51:   u = mk(fbr_pkg::OP_ADD, R_K, R_K, R_V);
                7'd52:   u = mk(fbr_pkg::OP_ADD, R_S2, R_V, R_S2);
                7'd53:   u = mk(fbr_pkg::OP_ADD, R_X1, R_L, R_PX);
                default: u = mk(fbr_pkg::OP_ADD, R_X2, R_K, R_PY);
            endcase
        end else if (pc < 7'd65) begin
            u = deriv_op(4'(pc - 7'd55));
        end else begin
            case (pc)
                7'd65:   u = mk(fbr_pkg::OP_ADD, R_S1, R_L, R_S1);
                7'd66:   u = mk(fbr_pkg::OP_ADD, R_S2, R_K, R_S2);
                7'd67:   u = mk(fbr_pkg::OP_MUL, R_SIX, R_S1, R_V);
                7'd68:   u = mk(fbr_pkg::OP_ADD, R_X1, R_V, R_X1);
                7'd69:   u = mk(fbr_pkg::OP_MUL, R_SIX, R_S2, R_V);
                default: u = mk(fbr_pkg::OP_ADD, R_X2, R_V, R_X2);
            endcase
        end
        return u;
    endfunction

    // registers of the configuration and of the working set
    fbr_pkg::val_t        a_reg, b_reg, c_reg, d_reg, st1_reg, st2_reg;
    logic [fbr_pkg::SW-1:0] h_reg;
    fbr_pkg::val_t        x1_reg, x2_reg, osc_reg;
    fbr_pkg::val_t        tmp_reg [R_PX:R_V];
    logic [1:0]           state_reg;
    logic [6:0]           pc_reg;

    uop_t                 uop;
    fbr_pkg::alu_cmd_t    cmd;
    fbr_pkg::val_t        opa, opb, res;
    logic                 done;

    // operand read: constants, registers or temporaries
    function automatic fbr_pkg::val_t rd_slot(logic [4:0] s,
        fbr_pkg::val_t a, fbr_pkg::val_t b, fbr_pkg::val_t c, fbr_pkg::val_t d,
        logic [fbr_pkg::SW-1:0] h, fbr_pkg::val_t o, fbr_pkg::val_t x1,
        fbr_pkg::val_t x2, fbr_pkg::val_t t);
        fbr_pkg::val_t v;
        case (s)
            R_ZERO:  v = '0;
            R_ONE:   v = fbr_pkg::ONE_C;
            R_HALF:  v = fbr_pkg::HALF_C;
            R_SIX:   v = fbr_pkg::SIXTH_C;
            R_A:     v = a;
            R_B:     v = b;
            R_C:     v = c;
            R_D:     v = d;
            R_H:     v = fbr_pkg::VW'(h);
            R_OSC:   v = o;
            R_X1:    v = x1;
            R_X2:    v = x2;
            default: v = t;
        endcase
        return v;
    endfunction

    always_comb begin
        uop = ucode(pc_reg);
        opa = rd_slot(uop.ra, a_reg, b_reg, c_reg, d_reg, h_reg, osc_reg,
                      x1_reg, x2_reg, (uop.ra >= R_PX) ? tmp_reg[uop.ra] : '0);
        opb = rd_slot(uop.rb, a_reg, b_reg, c_reg, d_reg, h_reg, osc_reg,
                      x1_reg, x2_reg, (uop.rb >= R_PX) ? tmp_reg[uop.rb] : '0);
        cmd.go = (state_reg == ST_ISSUE);
        cmd.op = uop.op;
    end

    fbr_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .done    (done),
        .res     (res)
    );

    // configuration write: always ready; out-of-range index dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg   <= fbr_pkg::VW'(64'sd50331648);
            b_reg   <= '0;
            c_reg   <= '0;
            d_reg   <= '0;
            h_reg   <= fbr_pkg::SW'(167772);
            st1_reg <= '0;
            st2_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                fbr_pkg::REG_A:  a_reg   <= cfg_data;
                fbr_pkg::REG_B:  b_reg   <= cfg_data;
                fbr_pkg::REG_C:  c_reg   <= cfg_data;
                fbr_pkg::REG_D:  d_reg   <= cfg_data;
                fbr_pkg::REG_H:  h_reg   <= cfg_data[fbr_pkg::SW-1:0];
                fbr_pkg::REG_S1: st1_reg <= cfg_data;
                fbr_pkg::REG_S2: st2_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // sequencer: issue one micro-op, wait for the unit, write back, advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            x1_reg    <= '0;
            x2_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        osc_reg <= fbr_pkg::VW'(s_forcing);
                        if (s_restart) begin
                            x1_reg <= st1_reg;
                            x2_reg <= st2_reg;
                        end
                        pc_reg    <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (done) begin
                        if (uop.rd == R_X1) begin
                            x1_reg <= res;
                        end else if (uop.rd == R_X2) begin
                            x2_reg <= res;
                        end else if (uop.rd >= R_PX) begin
                            tmp_reg[uop.rd] <= res;
                        end
                        if (pc_reg == 7'(NOPS - 1)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            pc_reg    <= pc_reg + 7'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_first_conc  = x1_reg;
    assign m_second_conc = x2_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(x1_reg) && $stable(x2_reg))
        else $error("result word changed while stalled");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result waits");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg < 7'(NOPS))
        else $error("micro-op counter out of range");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> state_reg == ST_WAIT)
        else $error("unit finished outside a wait");
endmodule

### design/fbr_alu.sv
// fbr_alu: shared saturating add/subtract/multiply unit for fbr.
// Depends on fbr_pkg. Multiply runs as 20x20 partial products summed in turn.
`timescale 1ns / 1ps
module fbr_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fbr_pkg::alu_cmd_t    cmd,
    input  fbr_pkg::val_t        opa,
    input  fbr_pkg::val_t        opb,
    output logic                 done,
    output fbr_pkg::val_t        res
);
    localparam int HW = fbr_pkg::VW / 2;
    localparam int LW = fbr_pkg::VW - HW;

    logic [fbr_pkg::VW-1:0]   ua_reg, ub_reg;
    logic                     neg_reg;
    logic [2*fbr_pkg::VW-1:0] acc_reg;
    logic [2:0]               cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    fbr_pkg::val_t            res_reg;

    logic signed [fbr_pkg::VW:0] sum;
    logic [fbr_pkg::VW-1:0]      ua, ub;
    logic [LW-1:0]               pa, pb;
    logic [2*LW-1:0]             pp;
    logic [2*fbr_pkg::VW-1:0]    pp_sh;
    logic [2*fbr_pkg::VW-1:0]    q;
    fbr_pkg::val_t               mres;

    always_comb begin
        if (cmd.op == fbr_pkg::OP_SUB) begin
            sum = {opa[fbr_pkg::VW-1], opa} - {opb[fbr_pkg::VW-1], opb};
        end else begin
            sum = {opa[fbr_pkg::VW-1], opa} + {opb[fbr_pkg::VW-1], opb};
        end
        ua = opa[fbr_pkg::VW-1] ? fbr_pkg::VW'(-opa) : opa;
        ub = opb[fbr_pkg::VW-1] ? fbr_pkg::VW'(-opb) : opb;
    end

    // partial product select: cnt 0 ll, 1 lh, 2 hl, 3 hh
    always_comb begin
        pa = cnt_reg[1] ? LW'(ua_reg[fbr_pkg::VW-1:LW]) : ua_reg[LW-1:0];
        pb = cnt_reg[0] ? LW'(ub_reg[fbr_pkg::VW-1:LW]) : ub_reg[LW-1:0];
        pp = pa * pb;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = (2*fbr_pkg::VW)'(pp);
            2'd3:    pp_sh = (2*fbr_pkg::VW)'(pp) << (2*LW);
            default: pp_sh = (2*fbr_pkg::VW)'(pp) << LW;
        endcase
        q = acc_reg >> fbr_pkg::FB;
        if (q > (2*fbr_pkg::VW)'(fbr_pkg::VMAX) + (neg_reg ? 1 : 0)) begin
            mres = neg_reg ? fbr_pkg::VMIN : fbr_pkg::VMAX;
        end else begin
            mres = neg_reg ? fbr_pkg::VW'(-q) : q[fbr_pkg::VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.go && cmd.op != fbr_pkg::OP_MUL) begin
                done_reg <= 1'b1;
                if (sum > $signed({fbr_pkg::VMAX[fbr_pkg::VW-1], fbr_pkg::VMAX})) begin
                    res_reg <= fbr_pkg::VMAX;
                end else if (sum < $signed({fbr_pkg::VMIN[fbr_pkg::VW-1], fbr_pkg::VMIN})) begin
                    res_reg <= fbr_pkg::VMIN;
                end else begin
                    res_reg <= sum[fbr_pkg::VW-1:0];
                end
            end else if (cmd.go) begin
                ua_reg   <= ua;
                ub_reg   <= ub;
                neg_reg  <= opa[fbr_pkg::VW-1] ^ opb[fbr_pkg::VW-1];
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= mres;
                end else begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg || $past(cmd.go))
        else $error("alu done held without a new command");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("alu partial-product count out of range");
    a_busy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == 3'd4 && !cmd.go) |=> done_reg)
        else $error("alu multiply finished without done");
endmodule

### test/testbench.sv
// testbench: self-checking bench for forced_brusselator_rk4_step.
// Depends on fbr_pkg and the block's RTL; drives random ticks and register
// writes, predicts each RK4 step in fixed point and checks every result word.
`timescale 1ns / 1ps
module testbench;
    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  DRAIN_CYCLES = 400;
    localparam longint MAX_V = (64'sd1 <<< (fbr_pkg::VW - 1)) - 1;
    localparam longint MIN_V = -(64'sd1 <<< (fbr_pkg::VW - 1));
    localparam longint ONE_Q = 64'sd1 <<< fbr_pkg::FB;
    // Register index with no register behind it.
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct {
        logic signed [fbr_pkg::FW-1:0] forcing;
        logic                          restart;
    } tick_t;

    typedef struct {
        longint first;
        longint second;
    } conc_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [fbr_pkg::FW-1:0] s_forcing = '0;
    logic s_restart = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [fbr_pkg::VW-1:0] m_first_conc;
    logic signed [fbr_pkg::VW-1:0] m_second_conc;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [fbr_pkg::VW-1:0] cfg_data = '0;

    // Ticks waiting to be sent, and concentrations expected back, oldest first.
    tick_t tick_q[$];
    conc_t conc_q[$];

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  hold_ticks = 1'b0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  ticks_sent = 0;
    int  words_checked = 0;
    int  reg_writes = 0;

    // Predictor copy of the registers and the two concentrations.
    longint feed_a, conv_b, auto_c, decay_d, step_h, init_first, init_second;
    longint conc_first, conc_second;

    forced_brusselator_rk4_step i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_forcing     (s_forcing),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_conc  (m_first_conc),
        .m_second_conc (m_second_conc),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Fixed-point arithmetic of the step: every operation clamps to VW bits.
    // ---------------------------------------------------------------------
    function automatic longint clamp(longint x);
        if (x > MAX_V) return MAX_V;
        if (x < MIN_V) return MIN_V;
        return x;
    endfunction

    function automatic longint add_q(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint sub_q(longint a, longint b);
        return clamp(a - b);
    endfunction

    // Full-precision product of magnitudes, truncated toward zero, then clamped.
    function automatic longint mul_q(longint a, longint b);
        logic [127:0] prod;
        logic [63:0]  ua;
        logic [63:0]  ub;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = ({64'd0, ua} * {64'd0, ub}) >> fbr_pkg::FB;
        if (prod > 128'(MAX_V))
            return neg ? MIN_V : MAX_V;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint cubic(longint x1, longint x2);
        return mul_q(mul_q(mul_q(auto_c, x1), x1), x2);
    endfunction

    function automatic longint rate_first(longint x1, longint x2, longint osc);
        longint feed;
        longint loss;
        feed = mul_q(feed_a, add_q(ONE_Q, osc));
        loss = mul_q(add_q(conv_b, decay_d), x1);
        return add_q(sub_q(feed, loss), cubic(x1, x2));
    endfunction

    function automatic longint rate_second(longint x1, longint x2);
        return sub_q(mul_q(conv_b, x1), cubic(x1, x2));
    endfunction

    // Advance the concentrations by one RK4 step and return the new pair.
    function automatic conc_t rk4_advance(tick_t tk);
        longint osc, half, x1, x2, px, py;
        longint l1, l2, l3, l4, k1, k2, k3, k4, s1, s2;
        conc_t  res;
        osc  = longint'(tk.forcing);
        half = longint'(fbr_pkg::HALF_C);
        if (tk.restart) begin
            conc_first  = init_first;
            conc_second = init_second;
        end
        x1 = conc_first;
        x2 = conc_second;
        l1 = mul_q(rate_first(x1, x2, osc), step_h);
        k1 = mul_q(rate_second(x1, x2), step_h);
        px = add_q(x1, mul_q(half, l1));
        py = add_q(x2, mul_q(half, k1));
        l2 = mul_q(rate_first(px, py, osc), step_h);
        k2 = mul_q(rate_second(px, py), step_h);
        px = add_q(x1, mul_q(half, l2));
        py = add_q(x2, mul_q(half, k2));
        l3 = mul_q(rate_first(px, py, osc), step_h);
        k3 = mul_q(rate_second(px, py), step_h);
        px = add_q(x1, l3);
        py = add_q(x2, k3);
        l4 = mul_q(rate_first(px, py, osc), step_h);
        k4 = mul_q(rate_second(px, py), step_h);
        s1 = add_q(add_q(add_q(l1, add_q(l2, l2)), add_q(l3, l3)), l4);
        s2 = add_q(add_q(add_q(k1, add_q(k2, k2)), add_q(k3, k3)), k4);
        conc_first  = add_q(x1, mul_q(longint'(fbr_pkg::SIXTH_C), s1));
        conc_second = add_q(x2, mul_q(longint'(fbr_pkg::SIXTH_C), s2));
        res.first  = conc_first;
        res.second = conc_second;
        return res;
    endfunction

    function automatic void store_reg(logic [2:0] idx, logic [fbr_pkg::VW-1:0] data);
        case (idx)
            fbr_pkg::REG_A:  feed_a      = longint'($signed(data));
            fbr_pkg::REG_B:  conv_b      = longint'($signed(data));
            fbr_pkg::REG_C:  auto_c      = longint'($signed(data));
            fbr_pkg::REG_D:  decay_d     = longint'($signed(data));
            fbr_pkg::REG_H:  step_h      = longint'({1'b0, data[fbr_pkg::SW-1:0]});
            fbr_pkg::REG_S1: init_first  = longint'($signed(data));
            fbr_pkg::REG_S2: init_second = longint'($signed(data));
            default: ;
        endcase
    endfunction

    task automatic report(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %0s on word %0d: got %0d, expected %0d",
                 what, words_checked, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Driver: feed ticks from the queue, predicting each one as it is taken.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        tick_t tk;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tk.forcing = s_forcing;
                tk.restart = s_restart;
                conc_q = {conc_q, rk4_advance(tk)};
                ticks_sent++;
            end
            // Hold the word until it is taken; otherwise offer the next one.
            if (!s_valid || s_ready) begin
                if (tick_q.size() > 0 && !hold_ticks &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    tk = tick_q.pop_front();
                    s_forcing <= tk.forcing;
                    s_restart <= tk.restart;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: stall at random and check each result word against the oldest
    // prediction.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        conc_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (conc_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    want = conc_q.pop_front();
                    if (longint'(m_first_conc) != want.first)
                        report("first_conc", longint'(m_first_conc), want.first);
                    if (longint'(m_second_conc) != want.second)
                        report("second_conc", longint'(m_second_conc), want.second);
                end
                words_checked++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, conc_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [fbr_pkg::VW-1:0] data);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        store_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_tick(logic signed [fbr_pkg::FW-1:0] f, logic r);
        tick_t tk;
        tk.forcing = f;
        tk.restart = r;
        tick_q = {tick_q, tk};
    endtask

    // Mostly forcing within plus or minus one, now and then anywhere in range.
    task automatic add_random_ticks(int n);
        logic signed [fbr_pkg::FW-1:0] f;
        repeat (n) begin
            if ($urandom_range(9) == 0)
                f = fbr_pkg::FW'($urandom);
            else
                f = fbr_pkg::FW'($signed($urandom_range(2 * ONE_Q)) - ONE_Q);
            add_tick(f, $urandom_range(19) == 0);
        end
    endtask

    task automatic drain;
        while (tick_q.size() > 0 || s_valid || conc_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Small random value in Q16.24, magnitude below 2^mag_bits.
    function automatic logic [fbr_pkg::VW-1:0] rand_q(int mag_bits);
        longint v;
        v = longint'($urandom_range((1 << mag_bits) - 1));
        return fbr_pkg::VW'($urandom_range(1) ? -v : v);
    endfunction

    task automatic load_plausible;
        write_reg(fbr_pkg::REG_A, rand_q(26));
        write_reg(fbr_pkg::REG_B, rand_q(26));
        write_reg(fbr_pkg::REG_C, rand_q(25));
        write_reg(fbr_pkg::REG_D, rand_q(24));
        write_reg(fbr_pkg::REG_H, fbr_pkg::VW'($urandom_range(1 << 22)));
        write_reg(fbr_pkg::REG_S1, rand_q(26));
        write_reg(fbr_pkg::REG_S2, rand_q(26));
    endtask

    task automatic set_pace(int idle_s, int stall_m);
        sender_idle_pct    = idle_s;
        receiver_stall_pct = stall_m;
    endtask

    initial begin
        feed_a = 64'sd50331648;
        conv_b = 0; auto_c = 0; decay_d = 0;
        step_h = 167772;
        init_first = 0; init_second = 0;
        conc_first = 0; conc_second = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, forcing extremes and restart both ways.
        set_pace(0, 0);
        add_tick(26'sh2000000, 1'b0);
        add_tick(26'sh1FFFFFF, 1'b0);
        add_tick(fbr_pkg::FW'(ONE_Q), 1'b0);
        add_tick(fbr_pkg::FW'(-ONE_Q), 1'b1);
        add_tick('0, 1'b0);
        drain();

        // Brusselator-like setting with a real oscillation.
        write_reg(fbr_pkg::REG_A, fbr_pkg::VW'(ONE_Q));
        write_reg(fbr_pkg::REG_B, fbr_pkg::VW'(3 * ONE_Q));
        write_reg(fbr_pkg::REG_C, fbr_pkg::VW'(ONE_Q));
        write_reg(fbr_pkg::REG_D, fbr_pkg::VW'(ONE_Q / 10));
        write_reg(fbr_pkg::REG_H, fbr_pkg::VW'(ONE_Q / 20));
        write_reg(fbr_pkg::REG_S1, fbr_pkg::VW'(ONE_Q + ONE_Q / 2));
        write_reg(fbr_pkg::REG_S2, fbr_pkg::VW'(2 * ONE_Q));
        add_tick('0, 1'b1);
        add_tick(fbr_pkg::FW'(ONE_Q), 1'b0);
        add_tick(fbr_pkg::FW'(-ONE_Q), 1'b0);
        add_tick(26'sh2000000, 1'b0);
        add_tick(26'sh1FFFFFF, 1'b1);
        drain();

        // Upper extremes; the step write carries ones above its 25 bits, and
        // an unused index is written too.
        write_reg(fbr_pkg::REG_A, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_B, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_C, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_D, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_H, '1);
        write_reg(fbr_pkg::REG_S1, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_S2, fbr_pkg::VW'(MAX_V));
        write_reg(REG_NONE, '1);
        add_tick('0, 1'b1);
        add_tick(26'sh1FFFFFF, 1'b0);
        add_tick(26'sh2000000, 1'b1);
        drain();

        // Lower extremes with a zero step, then a step of exactly one.
        write_reg(fbr_pkg::REG_A, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_B, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_C, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_D, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_H, '0);
        write_reg(fbr_pkg::REG_S1, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_S2, fbr_pkg::VW'(MIN_V));
        add_tick(26'sh1FFFFFF, 1'b1);
        add_tick(26'sh2000000, 1'b0);
        drain();
        write_reg(fbr_pkg::REG_H, fbr_pkg::VW'(ONE_Q));
        add_tick(fbr_pkg::FW'(ONE_Q / 2), 1'b1);
        add_tick(fbr_pkg::FW'(-ONE_Q / 2), 1'b0);
        add_tick('0, 1'b0);
        drain();

        // Random ticks under rotating pacing and fresh settings each phase.
        for (int ph = 0; ph < 12; ph++) begin
            load_plausible();
            case (ph % 4)
                0: set_pace(0, 0);
                1: set_pace(82, 0);
                2: set_pace(0, 82);
                default: set_pace(35, 35);
            endcase
            add_random_ticks(150);
            if (ph == 5) begin
                // Hold off mid-phase until every outstanding word is back.
                while (tick_q.size() > 75) @(posedge aclk);
                hold_ticks = 1'b1;
                while (s_valid || conc_q.size() > 0) @(posedge aclk);
                repeat (20) @(posedge aclk);
                hold_ticks = 1'b0;
            end
            drain();
        end

        // Close with the extremes once more under mixed pacing.
        write_reg(fbr_pkg::REG_A, fbr_pkg::VW'(MAX_V));
        write_reg(fbr_pkg::REG_C, fbr_pkg::VW'(MIN_V));
        write_reg(fbr_pkg::REG_H, fbr_pkg::VW'(ONE_Q));
        set_pace(35, 35);
        add_random_ticks(40);
        drain();

        $display("covered %0d ticks and %0d result words over %0d register writes",
                 ticks_sent, words_checked, reg_writes);
        $display("pacing from none to 82 percent idle on each side, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && conc_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
